[rtl/dctbhd_pkg.sv]
// Shared types, constants and the DCT basis table for the 3-D DCT denoiser.
package dctbhd_pkg;

    localparam int EDGE       = 4;
    localparam int VOL        = EDGE * EDGE * EDGE;
    localparam int ADDR_W     = 6;
    localparam int VOXEL_W    = 16;
    localparam int COEF_W     = 20;
    localparam int FILT_W     = 18;
    localparam int WEIGHT_W   = 17;
    localparam int PROD_W     = 36;
    localparam int SUM_W      = 38;

    localparam logic signed [COEF_W-1:0] COEF_MAX = 20'sd524287;
    localparam logic signed [COEF_W-1:0] COEF_MIN = -20'sd524288;

    // Register indexes on the configuration port.
    localparam logic REG_THRESHOLD  = 1'b0;
    localparam logic REG_PILOT_MODE = 1'b1;

    // Which block a transform pass works on.
    localparam logic [1:0] JOB_IMG = 2'd0;
    localparam logic [1:0] JOB_PLT = 2'd1;
    localparam logic [1:0] JOB_INV = 2'd2;

    // Orthonormal DCT-II basis in Q1.14, row r = frequency, column k = position.
    localparam logic signed [15:0] BASIS [16] = '{
        16'sd8192,  16'sd8192,   16'sd8192,  16'sd8192,
        16'sd10703, 16'sd4433,  -16'sd4433, -16'sd10703,
        16'sd8192, -16'sd8192,  -16'sd8192,  16'sd8192,
        16'sd4433, -16'sd10703,  16'sd10703, -16'sd4433
    };

    typedef enum logic [2:0] {
        S_LOAD,
        S_RD,
        S_MAC,
        S_THR,
        S_DIV,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_WAIT
    } t_state;

    typedef struct packed {
        logic       cap_en;
        logic [1:0] cap_idx;
        logic       mul_en;
        logic [1:0] mul_idx;
        logic       inverse;
    } t_mac_ctl;

    function automatic logic signed [15:0] basis(input logic [1:0] r, input logic [1:0] k);
        basis = BASIS[{r, k}];
    endfunction

    // Address of element i of a line; dir 0 runs along columns, 1 rows, 2 slices.
    function automatic logic [ADDR_W-1:0] line_addr(input logic [1:0] dir,
                                                    input logic [3:0] line,
                                                    input logic [1:0] i);
        case (dir)
            2'd0:    line_addr = {line, i};
            2'd1:    line_addr = {line[3:2], i, line[1:0]};
            default: line_addr = {i, line};
        endcase
    endfunction

endpackage

[rtl/dctbhd_ram.sv]
// Generic simple dual-port RAM with registered read.
module dctbhd_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/dctbhd_line.sv]
// One-dimensional DCT line unit: line buffer, four multipliers, sum, round and saturate.
module dctbhd_line (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  dctbhd_pkg::t_mac_ctl                 i_ctl,
    input  logic signed [dctbhd_pkg::COEF_W-1:0] i_data,
    output logic                                 o_valid,
    output logic [1:0]                           o_idx,
    output logic signed [dctbhd_pkg::COEF_W-1:0] o_result
);

    localparam int SUM_W = dctbhd_pkg::SUM_W;

    logic signed [dctbhd_pkg::COEF_W-1:0] r_line [4];
    logic signed [dctbhd_pkg::PROD_W-1:0] r_prod [4];
    logic                                 r_pv;
    logic [1:0]                           r_pidx;
    logic signed [dctbhd_pkg::SUM_W-1:0]  sum;
    logic signed [dctbhd_pkg::SUM_W-1:0]  rnd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap_en) begin
            r_line[i_ctl.cap_idx] <= i_data;
        end
        if (i_ctl.mul_en) begin
            for (int j = 0; j < 4; j++) begin
                // The inverse uses the transposed basis.
                if (i_ctl.inverse) begin
                    r_prod[j] <= dctbhd_pkg::basis(2'(j), i_ctl.mul_idx) * r_line[j];
                end else begin
                    r_prod[j] <= dctbhd_pkg::basis(i_ctl.mul_idx, 2'(j)) * r_line[j];
                end
            end
            r_pidx <= i_ctl.mul_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.mul_en;
        end
    end

    always_comb begin
        sum = SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]) + SUM_W'(r_prod[2]) + SUM_W'(r_prod[3]);
        rnd = (sum + 38'sd8192) >>> 14;
        if (rnd > 38'(dctbhd_pkg::COEF_MAX)) begin
            o_result = dctbhd_pkg::COEF_MAX;
        end else if (rnd < 38'(dctbhd_pkg::COEF_MIN)) begin
            o_result = dctbhd_pkg::COEF_MIN;
        end else begin
            o_result = rnd[dctbhd_pkg::COEF_W-1:0];
        end
    end

    assign o_valid = r_pv;
    assign o_idx   = r_pidx;

endmodule

[rtl/dct3d_block_hard_threshold_denoise.sv]
// Top level: 4x4x4 block 3-D DCT hard-threshold denoiser with APB configuration.
// Loading takes one word per cycle; nothing is taken while a block is processed or emitted.
// Each 1-D pass visits 16 lines, each with 4 reads, 4 products and a pipeline drain.
// Self mode runs 6 passes, pilot mode 9, plus thresholding and the weight divider; each
// result is then read, registered and held while stalled. A skipped block goes straight out.
// Reset is synchronous and active low; it clears control state, not the stores or output data.
module dct3d_block_hard_threshold_denoise (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_voxel,
    input  logic signed [15:0] i_pilot_voxel,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [17:0] o_filtered_value,
    output logic signed [19:0] o_coefficient,
    output logic [16:0]        o_weight,
    output logic               o_skipped,
    output logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CW = dctbhd_pkg::COEF_W;
    localparam int AW = dctbhd_pkg::ADDR_W;

    dctbhd_pkg::t_state r_state, n_state;

    logic [6:0]  r_cnt;
    logic [3:0]  r_line;
    logic [2:0]  r_c;
    logic [1:0]  r_job;
    logic [1:0]  r_dir;
    logic        r_anyp;
    logic [19:0] r_threshold;
    logic        r_pilot_mode;
    logic [19:0] r_thr_q;
    logic        r_mode_q;
    logic [6:0]  r_kept;
    logic        r_tv;
    logic [5:0]  r_tp;
    logic [6:0]  r_rem;
    logic [16:0] r_quo;
    logic [16:0] r_dvd;
    logic [4:0]  r_div_n;

    logic               r_o_valid;
    logic signed [17:0] r_o_filt;
    logic signed [19:0] r_o_coef;
    logic [16:0]        r_o_weight;
    logic               r_o_skipped;
    logic               r_o_last;

    logic          in_acc;
    logic          cfg_wr;
    logic          anyp_next;
    logic [AW-1:0] rd_addr;
    logic          vox_we, plt_we, wrk_we;
    logic [AW-1:0] plt_waddr;
    logic [CW-1:0] plt_wdata;
    logic [15:0]   q_vox;
    logic [CW-1:0] q_plt, q_wrk;
    logic signed [CW-1:0] src_data;
    logic signed [CW-1:0] tst;
    logic [CW:0]   mag;
    logic          keep;
    logic [7:0]    rem_sh;
    logic [7:0]    divisor;

    dctbhd_pkg::t_mac_ctl mac_ctl;
    logic                 mac_valid;
    logic [1:0]           mac_idx;
    logic signed [CW-1:0] mac_result;

    assign in_acc    = i_valid && (r_state == dctbhd_pkg::S_LOAD);
    assign cfg_wr    = psel && penable && pwrite;
    assign anyp_next = r_anyp || (i_voxel > 16'sd0);
    assign o_stall   = (r_state != dctbhd_pkg::S_LOAD);
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == dctbhd_pkg::REG_PILOT_MODE) ? {31'd0, r_pilot_mode}
                                                                : {12'd0, r_threshold};

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            dctbhd_pkg::S_LOAD: begin
                if (in_acc && r_cnt == 7'd63) begin
                    n_state = anyp_next ? dctbhd_pkg::S_RD : dctbhd_pkg::S_OUT_RD;
                end
            end
            dctbhd_pkg::S_RD: begin
                if (r_c == 3'd4) n_state = dctbhd_pkg::S_MAC;
            end
            dctbhd_pkg::S_MAC: begin
                if (r_c == 3'd4) begin
                    if (r_line == 4'd15 && r_dir == 2'd2) begin
                        if (r_job == dctbhd_pkg::JOB_INV) begin
                            n_state = dctbhd_pkg::S_DIV;
                        end else if (r_job == dctbhd_pkg::JOB_IMG && r_mode_q) begin
                            n_state = dctbhd_pkg::S_RD;
                        end else begin
                            n_state = dctbhd_pkg::S_THR;
                        end
                    end else begin
                        n_state = dctbhd_pkg::S_RD;
                    end
                end
            end
            dctbhd_pkg::S_THR: begin
                if (r_cnt == 7'd64) n_state = dctbhd_pkg::S_RD;
            end
            dctbhd_pkg::S_DIV: begin
                if (r_div_n == 5'd17) n_state = dctbhd_pkg::S_OUT_RD;
            end
            dctbhd_pkg::S_OUT_RD:   n_state = dctbhd_pkg::S_OUT_LD;
            dctbhd_pkg::S_OUT_LD:   n_state = dctbhd_pkg::S_OUT_WAIT;
            dctbhd_pkg::S_OUT_WAIT: begin
                if (!i_stall) begin
                    n_state = (r_cnt == 7'd63) ? dctbhd_pkg::S_LOAD : dctbhd_pkg::S_OUT_RD;
                end
            end
            default: n_state = dctbhd_pkg::S_LOAD;
        endcase
    end

    // Memory and datapath control.
    always_comb begin
        rd_addr   = r_cnt[AW-1:0];
        vox_we    = in_acc;
        wrk_we    = 1'b0;
        plt_we    = 1'b0;
        plt_waddr = r_cnt[AW-1:0];
        plt_wdata = CW'(i_pilot_voxel);
        mac_ctl   = '0;
        mac_ctl.inverse = (r_job == dctbhd_pkg::JOB_INV);
        case (r_state)
            dctbhd_pkg::S_LOAD: begin
                plt_we = in_acc;
            end
            dctbhd_pkg::S_RD: begin
                rd_addr         = dctbhd_pkg::line_addr(r_dir, r_line, r_c[1:0]);
                mac_ctl.cap_en  = (r_c != 3'd0);
                mac_ctl.cap_idx = 2'(r_c - 3'd1);
            end
            dctbhd_pkg::S_MAC: begin
                mac_ctl.mul_en  = (r_c != 3'd4);
                mac_ctl.mul_idx = r_c[1:0];
            end
            dctbhd_pkg::S_THR: begin
                plt_we    = r_tv;
                plt_waddr = r_tp;
                plt_wdata = keep ? q_wrk : '0;
            end
            default: ;
        endcase
        // Line unit writes back its registered results in the later product cycles and the drain.
        if (mac_valid) begin
            if (r_job == dctbhd_pkg::JOB_IMG) begin
                wrk_we = 1'b1;
            end else begin
                plt_we    = 1'b1;
                plt_wdata = mac_result;
            end
            plt_waddr = dctbhd_pkg::line_addr(r_dir, r_line, mac_idx);
        end
    end

    always_comb begin
        if (r_job == dctbhd_pkg::JOB_IMG && r_dir == 2'd0) begin
            src_data = CW'(signed'(q_vox));
        end else if (r_job == dctbhd_pkg::JOB_IMG) begin
            src_data = q_wrk;
        end else begin
            src_data = q_plt;
        end
        tst     = r_mode_q ? q_plt : q_wrk;
        mag     = tst[CW-1] ? (CW+1)'(-$signed({tst[CW-1], tst})) : {1'b0, tst};
        keep    = (mag >= {1'b0, r_thr_q});
        divisor = {1'b0, r_kept} + 8'd1;
        rem_sh  = {r_rem, r_dvd[16]};
    end

    dctbhd_ram #(.WIDTH(16), .DEPTH(64)) u_vox_ram (
        .i_clk   (i_clk),
        .i_we    (vox_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (i_voxel),
        .i_raddr (rd_addr),
        .o_rdata (q_vox)
    );

    dctbhd_ram #(.WIDTH(20), .DEPTH(64)) u_plt_ram (
        .i_clk   (i_clk),
        .i_we    (plt_we),
        .i_waddr (plt_waddr),
        .i_wdata (plt_wdata),
        .i_raddr (rd_addr),
        .o_rdata (q_plt)
    );

    dctbhd_ram #(.WIDTH(20), .DEPTH(64)) u_wrk_ram (
        .i_clk   (i_clk),
        .i_we    (wrk_we),
        .i_waddr (plt_waddr),
        .i_wdata (mac_result),
        .i_raddr (rd_addr),
        .o_rdata (q_wrk)
    );

    dctbhd_line u_line (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_data   (src_data),
        .o_valid  (mac_valid),
        .o_idx    (mac_idx),
        .o_result (mac_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= dctbhd_pkg::S_LOAD;
            r_cnt        <= '0;
            r_line       <= '0;
            r_c          <= '0;
            r_job        <= dctbhd_pkg::JOB_IMG;
            r_dir        <= '0;
            r_anyp       <= 1'b0;
            r_threshold  <= '0;
            r_pilot_mode <= 1'b0;
            r_thr_q      <= '0;
            r_mode_q     <= 1'b0;
            r_kept       <= '0;
            r_tv         <= 1'b0;
            r_tp         <= '0;
            r_rem        <= '0;
            r_quo        <= '0;
            r_dvd        <= '0;
            r_div_n      <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                if (paddr[2] == dctbhd_pkg::REG_THRESHOLD) r_threshold <= pwdata[19:0];
                else r_pilot_mode <= pwdata[0];
            end
            case (r_state)
                dctbhd_pkg::S_LOAD: begin
                    if (in_acc) begin
                        r_anyp <= anyp_next;
                        if (r_cnt == 7'd63) begin
                            r_cnt    <= '0;
                            r_thr_q  <= r_threshold;
                            r_mode_q <= r_pilot_mode;
                            r_job    <= dctbhd_pkg::JOB_IMG;
                            r_dir    <= '0;
                            r_line   <= '0;
                            r_c      <= '0;
                            r_kept   <= '0;
                        end else begin
                            r_cnt <= r_cnt + 7'd1;
                        end
                    end
                end
                dctbhd_pkg::S_RD: begin
                    r_c <= (r_c == 3'd4) ? 3'd0 : r_c + 3'd1;
                end
                dctbhd_pkg::S_MAC: begin
                    if (r_c == 3'd4) begin
                        r_c    <= '0;
                        r_line <= r_line + 4'd1;
                        if (r_line == 4'd15) begin
                            if (r_dir != 2'd2) begin
                                r_dir <= r_dir + 2'd1;
                            end else begin
                                r_dir <= '0;
                                if (r_job == dctbhd_pkg::JOB_IMG && r_mode_q) begin
                                    r_job <= dctbhd_pkg::JOB_PLT;
                                end
                                r_cnt   <= '0;
                                r_tv    <= 1'b0;
                                r_div_n <= '0;
                            end
                        end
                    end else begin
                        r_c <= r_c + 3'd1;
                    end
                end
                dctbhd_pkg::S_THR: begin
                    r_tv <= (r_cnt != 7'd64);
                    r_tp <= r_cnt[AW-1:0];
                    if (r_tv && keep) r_kept <= r_kept + 7'd1;
                    if (r_cnt == 7'd64) begin
                        r_cnt  <= '0;
                        r_job  <= dctbhd_pkg::JOB_INV;
                        r_dir  <= '0;
                        r_line <= '0;
                        r_c    <= '0;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                dctbhd_pkg::S_DIV: begin
                    // Restoring division of 65536 + (kept+1)/2 by kept+1, one bit a cycle.
                    r_div_n <= r_div_n + 5'd1;
                    if (r_div_n == 5'd0) begin
                        r_dvd <= 17'd65536 + 17'(divisor >> 1);
                        r_rem <= '0;
                        r_quo <= '0;
                    end else begin
                        r_dvd <= {r_dvd[15:0], 1'b0};
                        if (rem_sh >= divisor) begin
                            r_rem <= 7'(rem_sh - divisor);
                            r_quo <= {r_quo[15:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh[6:0];
                            r_quo <= {r_quo[15:0], 1'b0};
                        end
                    end
                end
                dctbhd_pkg::S_OUT_LD: begin
                    r_o_valid <= 1'b1;
                end
                dctbhd_pkg::S_OUT_WAIT: begin
                    if (!i_stall) begin
                        r_o_valid <= 1'b0;
                        if (r_cnt == 7'd63) begin
                            r_cnt  <= '0;
                            r_anyp <= 1'b0;
                        end else begin
                            r_cnt <= r_cnt + 7'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Output word registers.
    always_ff @(posedge i_clk) begin
        if (r_state == dctbhd_pkg::S_OUT_LD) begin
            r_o_skipped <= !r_anyp;
            r_o_last    <= (r_cnt == 7'd63);
            if (!r_anyp) begin
                r_o_filt   <= '0;
                r_o_coef   <= '0;
                r_o_weight <= '0;
            end else begin
                if ($signed(q_plt) > 20'sd131071) r_o_filt <= 18'sd131071;
                else if ($signed(q_plt) < -20'sd131072) r_o_filt <= -18'sd131072;
                else r_o_filt <= q_plt[17:0];
                r_o_coef   <= q_wrk;
                r_o_weight <= r_quo;
            end
        end
    end

    assign o_valid          = r_o_valid;
    assign o_filtered_value = r_o_filt;
    assign o_coefficient    = r_o_coef;
    assign o_weight         = r_o_weight;
    assign o_skipped        = r_o_skipped;
    assign o_last           = r_o_last;

endmodule
